FILE: rtl/bsa_pkg.sv
// Shared types and constants for the banker's-algorithm allocator.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package bsa_pkg;

  // default sizing, handed to the top-level parameters
  localparam int THREADS_DEF     = 8;
  localparam int RESOURCES_DEF   = 4;
  localparam int COUNT_WIDTH_DEF = 8;

  // fixed field widths of the channels
  localparam int CMD_W     = 2;
  localparam int TID_IN_W  = 3;
  localparam int AMT_W     = 8;
  localparam int AMT_N     = 4;
  localparam int STATUS_W  = 3;
  localparam int AID_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;
  localparam int CFG_N     = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESTART = 2'd0,
    CMD_ADD_MAX = 2'd1,
    CMD_REQUEST = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_OVER_NEED   = 3'd1,
    ST_OVER_AVAIL  = 3'd2,
    ST_UNSAFE      = 3'd3,
    ST_BAD_ID      = 3'd4,
    ST_TABLE_FULL  = 3'd5
  } status_e;

  // flags from the shared lane unit
  typedef struct packed {
    logic over_need;
    logic over_pool;
    logic fits;
  } unit_flags_t;

endpackage

`default_nettype wire

FILE: rtl/bsa_ifs.sv
// Valid/ready channel interfaces of the allocator: command in, result out,
// register write. Depends on bsa_pkg for field widths.
`default_nettype none

interface bsa_in_if;
  logic                          valid;
  logic                          ready;
  logic [bsa_pkg::CMD_W-1:0]     command;
  logic [bsa_pkg::TID_IN_W-1:0]  thread_id;
  logic [bsa_pkg::AMT_W-1:0]     amount_0;
  logic [bsa_pkg::AMT_W-1:0]     amount_1;
  logic [bsa_pkg::AMT_W-1:0]     amount_2;
  logic [bsa_pkg::AMT_W-1:0]     amount_3;

  modport source (output valid, command, thread_id, amount_0, amount_1, amount_2, amount_3,
                  input ready);
  modport sink   (input valid, command, thread_id, amount_0, amount_1, amount_2, amount_3,
                  output ready);
endinterface

interface bsa_out_if;
  logic                          valid;
  logic                          ready;
  logic                          granted;
  logic [bsa_pkg::STATUS_W-1:0]  status;
  logic [bsa_pkg::AID_W-1:0]     assigned_id;

  modport source (output valid, granted, status, assigned_id, input ready);
  modport sink   (input valid, granted, status, assigned_id, output ready);
endinterface

interface bsa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bsa_pkg::CFG_IDX_W-1:0]  index;
  logic [bsa_pkg::CFG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/bsa_lane_unit.sv
// Shared per-resource arithmetic: need, bounds compares, saturating return
// and pool subtraction across all lanes. Depends on bsa_pkg.
`default_nettype none

module bsa_lane_unit #(
  parameter int RESOURCES   = bsa_pkg::RESOURCES_DEF,
  parameter int COUNT_WIDTH = bsa_pkg::COUNT_WIDTH_DEF
) (
  input  var logic [RESOURCES-1:0][COUNT_WIDTH-1:0] max_i,
  input  var logic [RESOURCES-1:0][COUNT_WIDTH-1:0] alloc_i,
  input  var logic [RESOURCES-1:0][COUNT_WIDTH-1:0] req_i,
  input  var logic [RESOURCES-1:0][COUNT_WIDTH-1:0] pool_i,
  output bsa_pkg::unit_flags_t                      flags_o,
  output logic [RESOURCES-1:0][COUNT_WIDTH-1:0]     sum_o,
  output logic [RESOURCES-1:0][COUNT_WIDTH-1:0]     diff_o,
  output logic [RESOURCES-1:0][COUNT_WIDTH-1:0]     eff_o
);

  logic [RESOURCES-1:0][COUNT_WIDTH-1:0] need;
  logic [RESOURCES-1:0][COUNT_WIDTH-1:0] need_eff;
  logic [RESOURCES-1:0][COUNT_WIDTH:0]   wide;

  always_comb begin
    flags_o = '{over_need: 1'b0, over_pool: 1'b0, fits: 1'b1};
    for (int r = 0; r < RESOURCES; r++) begin
      need[r]     = max_i[r] - alloc_i[r];
      eff_o[r]    = alloc_i[r] + req_i[r];
      need_eff[r] = max_i[r] - eff_o[r];
      wide[r]     = {1'b0, pool_i[r]} + {1'b0, eff_o[r]};
      // saturate at all ones
      sum_o[r]    = wide[r][COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : wide[r][COUNT_WIDTH-1:0];
      diff_o[r]   = pool_i[r] - req_i[r];
      if (req_i[r] > need[r]) begin
        flags_o.over_need = 1'b1;
      end
      if (req_i[r] > pool_i[r]) begin
        flags_o.over_pool = 1'b1;
      end
      if (need_eff[r] > pool_i[r]) begin
        flags_o.fits = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bankers_safe_allocator_unit.sv
// Sequence: restart, add-max and bad-id commands go from idle straight to the result hand-off;
//   release and requests first read the addressed client's table row, then check or release.
//   A request passing the checks walks the C registered clients in P <= C passes; each client
//   visit is one table read plus one lane-unit evaluation. The walk stops as soon as the last
//   client finishes, or ends unsafe after a pass in which no client finished.
// Throughput: one command at a time; the result register frees the input during hand-off.
// Reset: rst_ni clears pool, client count, allocation valid bits and registers at once; no sweep.
// Depends on bsa_pkg, bsa_ifs (channel interfaces) and bsa_lane_unit.
`default_nettype none

module bankers_safe_allocator_unit #(
  parameter int THREADS     = bsa_pkg::THREADS_DEF,
  parameter int RESOURCES   = bsa_pkg::RESOURCES_DEF,
  parameter int COUNT_WIDTH = bsa_pkg::COUNT_WIDTH_DEF
) (
  input  var logic   clk_i,
  input  var logic   rst_ni,
  bsa_in_if.sink     in_i,
  bsa_out_if.source  out_o,
  bsa_cfg_if.sink    cfg_i
);

  // address into the client table, and a counter that can hold THREADS itself
  localparam int TID_W = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int CNT_W = $clog2(THREADS + 1);
  localparam int CMP_W = (CNT_W > bsa_pkg::TID_IN_W) ? CNT_W : bsa_pkg::TID_IN_W;

  typedef logic [RESOURCES-1:0][COUNT_WIDTH-1:0] row_t;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a command
    S_RD,     // table read of the addressed client
    S_CHK,    // need / available checks, or release
    S_SRD,    // table read during the safety walk
    S_SEV,    // evaluate one client of the safety walk
    S_DONE    // hand result to the output register
  } state_e;

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  state_e                          state_q;
  bsa_pkg::cmd_e                   cmd_q;
  logic [bsa_pkg::TID_IN_W-1:0]    id_q;
  row_t                            amt_q;
  row_t                            avail_q;     // units free right now
  row_t                            work_q;      // pool of the safety walk
  row_t                            nav_q;       // pool after the request
  row_t                            idalloc_q;   // requester's allocation after the request
  logic [THREADS-1:0]              done_q;      // clients finished in the walk
  logic [THREADS-1:0]              vld_q;       // allocation row holds data, else zero
  logic [CNT_W-1:0]                cnt_q;       // registered clients
  logic [CNT_W-1:0]                left_q;      // clients not yet finished
  logic                            prog_q;      // a client finished in this pass
  logic [TID_W-1:0]                rd_addr_q;
  logic [bsa_pkg::CFG_W-1:0]       cfg_q [bsa_pkg::CFG_N];

  logic                            res_granted_q;
  bsa_pkg::status_e                res_status_q;
  logic [bsa_pkg::AID_W-1:0]       res_aid_q;

  logic                            out_valid_q;
  logic                            out_granted_q;
  bsa_pkg::status_e                out_status_q;
  logic [bsa_pkg::AID_W-1:0]       out_aid_q;

  // client table: max claim is undefined until written; allocation is gated by vld_q
  row_t                            max_mem   [THREADS];
  row_t                            alloc_mem [THREADS];
  row_t                            max_rd_q;
  row_t                            alloc_rd_q;
  logic                            vld_rd_q;

  // ------------------------------------------------------------------
  // Input decode
  // ------------------------------------------------------------------
  logic [bsa_pkg::AMT_W-1:0]       in_amt [bsa_pkg::AMT_N];
  row_t                            amt_in;
  bsa_pkg::cmd_e                   in_cmd;
  logic                            in_acc;
  logic                            id_bad;
  logic                            table_full;
  logic                            max_we;

  assign in_amt[0] = in_i.amount_0;
  assign in_amt[1] = in_i.amount_1;
  assign in_amt[2] = in_i.amount_2;
  assign in_amt[3] = in_i.amount_3;
  assign in_cmd    = bsa_pkg::cmd_e'(in_i.command);
  assign in_acc    = in_i.valid && in_i.ready;

  always_comb begin
    // kinds beyond the four amount fields are zero; amounts fit to the count width
    for (int r = 0; r < RESOURCES; r++) begin
      amt_in[r] = (r < bsa_pkg::AMT_N) ? COUNT_WIDTH'(in_amt[r % bsa_pkg::AMT_N]) : '0;
    end
  end

  assign id_bad     = CMP_W'(in_i.thread_id) >= CMP_W'(cnt_q);
  assign table_full = cnt_q == CNT_W'(THREADS);
  assign max_we     = in_acc && (in_cmd == bsa_pkg::CMD_ADD_MAX) && !table_full;

  // ------------------------------------------------------------------
  // Shared lane unit and its operand selection
  // ------------------------------------------------------------------
  row_t                            alloc_eff;
  row_t                            pool;
  row_t                            req;
  row_t                            u_sum;
  row_t                            u_diff;
  row_t                            u_eff;
  bsa_pkg::unit_flags_t            u_flags;
  logic                            is_who;
  logic                            fin;
  logic                            alloc_we;
  logic                            last;
  logic                            out_load;
  logic [CNT_W-1:0]                left_d;

  assign is_who = CMP_W'(rd_addr_q) == CMP_W'(id_q);

  always_comb begin
    alloc_eff = vld_rd_q ? alloc_rd_q : '0;
    pool      = (state_q == S_SEV) ? work_q : avail_q;
    req       = '0;
    // request checks, and the requester's own row in the walk, see the requested units
    if ((state_q == S_CHK) && (cmd_q == bsa_pkg::CMD_REQUEST)) begin
      req = amt_q;
    end
    if ((state_q == S_SEV) && is_who) begin
      req = amt_q;
    end
  end

  assign fin      = (state_q == S_SEV) && !done_q[rd_addr_q] && u_flags.fits;
  assign left_d   = left_q - CNT_W'(fin);
  // last client finishing means the state is safe: commit
  assign alloc_we = fin && (left_q == CNT_W'(1));
  assign last     = (CNT_W'(rd_addr_q) + CNT_W'(1)) == cnt_q;
  // result register takes a new transaction when empty or being emptied
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  bsa_lane_unit #(
    .RESOURCES   (RESOURCES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_lane (
    .max_i   (max_rd_q),
    .alloc_i (alloc_eff),
    .req_i   (req),
    .pool_i  (pool),
    .flags_o (u_flags),
    .sum_o   (u_sum),
    .diff_o  (u_diff),
    .eff_o   (u_eff)
  );

  // ------------------------------------------------------------------
  // Client table
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    max_rd_q   <= max_mem[rd_addr_q];
    alloc_rd_q <= alloc_mem[rd_addr_q];
    vld_rd_q   <= vld_q[rd_addr_q];
    if (max_we) begin
      max_mem[TID_W'(cnt_q)] <= amt_in;
    end
    if (alloc_we) begin
      alloc_mem[TID_W'(id_q)] <= idalloc_q;
    end
  end

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  assign in_i.ready  = state_q == S_IDLE;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cmd_q         <= bsa_pkg::CMD_RESTART;
      id_q          <= '0;
      amt_q         <= '0;
      avail_q       <= '0;
      work_q        <= '0;
      nav_q         <= '0;
      idalloc_q     <= '0;
      done_q        <= '0;
      vld_q         <= '0;
      cnt_q         <= '0;
      left_q        <= '0;
      prog_q        <= 1'b0;
      rd_addr_q     <= '0;
      for (int i = 0; i < bsa_pkg::CFG_N; i++) begin
        cfg_q[i] <= '0;
      end
      res_granted_q <= 1'b0;
      res_status_q  <= bsa_pkg::ST_OK;
      res_aid_q     <= '0;
      out_valid_q   <= 1'b0;
      out_granted_q <= 1'b0;
      out_status_q  <= bsa_pkg::ST_OK;
      out_aid_q     <= '0;
    end else begin
      if (cfg_i.valid) begin
        cfg_q[cfg_i.index] <= cfg_i.data;
      end

      if (out_load) begin
        out_valid_q   <= 1'b1;
        out_granted_q <= res_granted_q;
        out_status_q  <= res_status_q;
        out_aid_q     <= res_aid_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q         <= in_cmd;
            id_q          <= in_i.thread_id;
            amt_q         <= amt_in;
            res_granted_q <= 1'b0;
            unique case (in_cmd) inside
              bsa_pkg::CMD_RESTART: begin
                vld_q        <= '0;
                cnt_q        <= '0;
                for (int r = 0; r < RESOURCES; r++) begin
                  avail_q[r] <= (r < bsa_pkg::CFG_N) ?
                                COUNT_WIDTH'(cfg_q[r % bsa_pkg::CFG_N]) : '0;
                end
                res_status_q <= bsa_pkg::ST_OK;
                res_aid_q    <= '0;
                state_q      <= S_DONE;
              end
              bsa_pkg::CMD_ADD_MAX: begin
                state_q <= S_DONE;
                if (table_full) begin
                  res_status_q <= bsa_pkg::ST_TABLE_FULL;
                  res_aid_q    <= '0;
                end else begin
                  vld_q[TID_W'(cnt_q)] <= 1'b0;
                  res_status_q         <= bsa_pkg::ST_OK;
                  res_aid_q            <= bsa_pkg::AID_W'(cnt_q);
                  cnt_q                <= cnt_q + CNT_W'(1);
                end
              end
              bsa_pkg::CMD_REQUEST, bsa_pkg::CMD_RELEASE: begin
                res_aid_q <= '0;
                if (id_bad) begin
                  res_status_q <= bsa_pkg::ST_BAD_ID;
                  state_q      <= S_DONE;
                end else begin
                  res_status_q <= bsa_pkg::ST_OK;
                  rd_addr_q    <= TID_W'(in_i.thread_id);
                  state_q      <= S_RD;
                end
              end
              default: begin
                res_status_q <= bsa_pkg::ST_OK;
                res_aid_q    <= '0;
                state_q      <= S_DONE;
              end
            endcase
          end
        end

        S_RD: begin
          state_q <= S_CHK;
        end

        S_CHK: begin
          if (cmd_q == bsa_pkg::CMD_RELEASE) begin
            // saturating return of the whole allocation
            avail_q               <= u_sum;
            vld_q[TID_W'(id_q)]   <= 1'b0;
            state_q               <= S_DONE;
          end else if (u_flags.over_need) begin
            res_status_q <= bsa_pkg::ST_OVER_NEED;
            state_q      <= S_DONE;
          end else if (u_flags.over_pool) begin
            res_status_q <= bsa_pkg::ST_OVER_AVAIL;
            state_q      <= S_DONE;
          end else begin
            nav_q     <= u_diff;
            work_q    <= u_diff;
            idalloc_q <= u_eff;
            done_q    <= '0;
            left_q    <= cnt_q;
            prog_q    <= 1'b0;
            rd_addr_q <= '0;
            state_q   <= S_SRD;
          end
        end

        S_SRD: begin
          state_q <= S_SEV;
        end

        S_SEV: begin
          if (fin) begin
            work_q            <= u_sum;
            done_q[rd_addr_q] <= 1'b1;
            left_q            <= left_d;
          end
          if (alloc_we) begin
            avail_q             <= nav_q;
            vld_q[TID_W'(id_q)] <= 1'b1;
            res_granted_q       <= 1'b1;
            state_q             <= S_DONE;
          end else if (last) begin
            // end of a pass: another one only if somebody finished
            if (prog_q || fin) begin
              prog_q    <= 1'b0;
              rd_addr_q <= '0;
              state_q   <= S_SRD;
            end else begin
              res_status_q <= bsa_pkg::ST_UNSAFE;
              state_q      <= S_DONE;
            end
          end else begin
            prog_q    <= prog_q || fin;
            rd_addr_q <= rd_addr_q + TID_W'(1);
            state_q   <= S_SRD;
          end
        end

        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.granted     = out_granted_q;
  assign out_o.status      = out_status_q;
  assign out_o.assigned_id = out_aid_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(THREADS))
    else $error("client count above table size");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_granted_q) |-> (out_status_q == bsa_pkg::ST_OK))
    else $error("grant with non-ok status");

  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SEV) || (state_q == S_SRD)) |->
      (($countones(done_q) + int'(left_q)) == int'(cnt_q)))
    else $error("finished and remaining clients disagree");

  a_walk_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEV) |-> (CNT_W'(rd_addr_q) < cnt_q))
    else $error("safety walk beyond registered clients");

  a_commit_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_we |=> ((state_q == S_DONE) && res_granted_q))
    else $error("commit without grant result");

endmodule

`default_nettype wire
